// File: hw/rtl/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/rqff_pkg.sv
package rqff_pkg;

   // default sizing
   localparam int MaxRules      = 8;
   localparam int NumRulesDef   = 8;
   localparam int LengthBitsDef = 16;

   // field widths
   localparam int QualBits      = 8;
   localparam int OffsetBits    = 7;
   localparam int RuleCountBits = 4;
   localparam int ThreshBits    = 7;
   localparam int FracBits      = 16;
   localparam int FracShift     = 15;
   localparam int OutLenBits    = 16;
   localparam int CsrAddrBits   = 3;
   localparam int CsrDataBits   = 64;

   // register reset values
   localparam logic [OffsetBits-1:0]    PhredOffsetRst = 7'd33;
   localparam logic [RuleCountBits-1:0] RuleCountRst   = 4'd1;

   // register indexes
   localparam logic [CsrAddrBits-1:0] CSR_PHRED_OFFSET = 3'd0;
   localparam logic [CsrAddrBits-1:0] CSR_RULE_COUNT   = 3'd1;
   localparam logic [CsrAddrBits-1:0] CSR_THRESHOLDS   = 3'd2;
   localparam logic [CsrAddrBits-1:0] CSR_FRAC_LOW     = 3'd3;
   localparam logic [CsrAddrBits-1:0] CSR_FRAC_HIGH    = 3'd4;

   typedef struct packed {
      logic [QualBits-1:0] quality_char;
      logic                char_valid;
      logic                last_of_read;
   } req_data_type;

   typedef struct packed {
      logic                  keep_read;
      logic [MaxRules-1:0]   rule_pass_mask;
      logic [OutLenBits-1:0] read_length;
      logic                  overlong;
   } rsp_data_type;

endpackage

// File: hw/rtl/read_quality_fraction_filter_top.sv
// path: a closing word passes through the input, snapshot and product registers into the result register
// throughput: one word per cycle; every stage advances together unless the
// result register is full and stalled
// reset: synchronous, clears all valid flags and per-read counters and
// returns the configuration registers to their reset values
`include "assert_macros.svh"

module read_quality_fraction_filter_top #(
   parameter int NUM_RULES   = rqff_pkg::NumRulesDef,
   parameter int LENGTH_BITS = rqff_pkg::LengthBitsDef
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  rqff_pkg::req_data_type               req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output rqff_pkg::rsp_data_type               rsp_data,
   input  logic                                 csr_we,
   input  logic [rqff_pkg::CsrAddrBits-1:0]     csr_addr,
   input  logic [rqff_pkg::CsrDataBits-1:0]     csr_wdata
);

   localparam int ProdBits = LENGTH_BITS + rqff_pkg::FracBits;
   localparam int ThrTotal = rqff_pkg::MaxRules * rqff_pkg::ThreshBits;
   localparam int FrcTotal = rqff_pkg::MaxRules * rqff_pkg::FracBits;
   localparam logic [LENGTH_BITS-1:0] CntMax = '1;
   localparam logic [31:0] OutLenMax = 32'((64'd1 << rqff_pkg::OutLenBits) - 64'd1);

   // configuration registers
   logic [rqff_pkg::OffsetBits-1:0]    phred_offset_ff, phred_offset_in;
   logic [rqff_pkg::RuleCountBits-1:0] rule_count_ff, rule_count_in;
   logic [ThrTotal-1:0]                rule_thresholds_ff, rule_thresholds_in;
   logic [FrcTotal-1:0]                rule_fractions_ff, rule_fractions_in;

   // input stage
   logic                   in_valid_ff, in_valid_in;
   rqff_pkg::req_data_type in_data_ff, in_data_in;

   // live per-read counters
   logic [LENGTH_BITS-1:0] char_count_ff, char_count_in;
   logic [LENGTH_BITS-1:0] hit_count_ff [NUM_RULES];
   logic [LENGTH_BITS-1:0] hit_count_in [NUM_RULES];
   logic                   overlong_seen_ff, overlong_seen_in;

   // closed-read snapshot
   logic                   snap_valid_ff, snap_valid_in;
   logic [LENGTH_BITS-1:0] snap_len_ff, snap_len_in;
   logic [LENGTH_BITS-1:0] snap_hit_ff [NUM_RULES];
   logic [LENGTH_BITS-1:0] snap_hit_in [NUM_RULES];
   logic                   snap_ovl_ff, snap_ovl_in;

   // product stage
   logic                   prod_valid_ff, prod_valid_in;
   logic [ProdBits-1:0]    prod_ff [NUM_RULES];
   logic [ProdBits-1:0]    prod_in [NUM_RULES];
   logic [LENGTH_BITS-1:0] prod_hit_ff [NUM_RULES];
   logic [LENGTH_BITS-1:0] prod_hit_in [NUM_RULES];
   logic [LENGTH_BITS-1:0] prod_len_ff, prod_len_in;
   logic                   prod_ovl_ff, prod_ovl_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   rqff_pkg::rsp_data_type rsp_data_ff, rsp_data_in;

   logic                   advance;
   logic                   counting;
   logic                   closing;
   logic [LENGTH_BITS-1:0] len_upd;
   logic                   ovl_upd;
   logic [LENGTH_BITS-1:0] hit_upd [NUM_RULES];
   logic [NUM_RULES-1:0]   rule_fail;
   logic [31:0]            len_wide;

   // whole pipeline moves when the result register can take a word
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // configuration writes
   always_comb begin
      phred_offset_in    = phred_offset_ff;
      rule_count_in      = rule_count_ff;
      rule_thresholds_in = rule_thresholds_ff;
      rule_fractions_in  = rule_fractions_ff;
      if (csr_we) begin
         unique case (csr_addr)
            rqff_pkg::CSR_PHRED_OFFSET: begin
               phred_offset_in = csr_wdata[rqff_pkg::OffsetBits-1:0];
            end
            rqff_pkg::CSR_RULE_COUNT: begin
               rule_count_in = csr_wdata[rqff_pkg::RuleCountBits-1:0];
            end
            rqff_pkg::CSR_THRESHOLDS: begin
               rule_thresholds_in = csr_wdata[ThrTotal-1:0];
            end
            rqff_pkg::CSR_FRAC_LOW: begin
               rule_fractions_in[FrcTotal/2-1:0] = csr_wdata[FrcTotal/2-1:0];
            end
            rqff_pkg::CSR_FRAC_HIGH: begin
               rule_fractions_in[FrcTotal-1:FrcTotal/2] = csr_wdata[FrcTotal/2-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // input register
   always_comb begin
      in_valid_in = advance ? req_valid : in_valid_ff;
      in_data_in  = (advance && req_valid) ? req_data : in_data_ff;
   end

   // count the word; score >= threshold is char >= threshold + offset
   assign counting = in_valid_ff && in_data_ff.char_valid;
   assign closing  = in_valid_ff && in_data_ff.last_of_read;

   always_comb begin
      logic [rqff_pkg::QualBits-1:0] thr_sum;
      len_upd = char_count_ff;
      ovl_upd = overlong_seen_ff;
      if (counting) begin
         if (char_count_ff == CntMax) begin
            ovl_upd = 1'b1;
         end else begin
            len_upd = char_count_ff + 1'b1;
         end
      end
      for (int r = 0; r < NUM_RULES; r++) begin
         thr_sum = {1'b0, rule_thresholds_ff[r*rqff_pkg::ThreshBits +: rqff_pkg::ThreshBits]}
                 + {1'b0, phred_offset_ff};
         hit_upd[r] = hit_count_ff[r];
         if (counting && (in_data_ff.quality_char >= thr_sum) && (hit_count_ff[r] != CntMax)) begin
            hit_upd[r] = hit_count_ff[r] + 1'b1;
         end
      end
   end

   // live counters clear on the closing word, the snapshot takes their final values
   always_comb begin
      char_count_in    = char_count_ff;
      overlong_seen_in = overlong_seen_ff;
      snap_valid_in    = snap_valid_ff;
      snap_len_in      = snap_len_ff;
      snap_ovl_in      = snap_ovl_ff;
      for (int r = 0; r < NUM_RULES; r++) begin
         hit_count_in[r] = hit_count_ff[r];
         snap_hit_in[r]  = snap_hit_ff[r];
      end
      if (advance) begin
         snap_valid_in = closing;
         if (closing) begin
            char_count_in    = '0;
            overlong_seen_in = 1'b0;
            snap_len_in      = len_upd;
            snap_ovl_in      = ovl_upd;
            for (int r = 0; r < NUM_RULES; r++) begin
               hit_count_in[r] = '0;
               snap_hit_in[r]  = hit_upd[r];
            end
         end else begin
            char_count_in    = len_upd;
            overlong_seen_in = ovl_upd;
            for (int r = 0; r < NUM_RULES; r++) begin
               hit_count_in[r] = hit_upd[r];
            end
         end
      end
   end

   // fraction times length, one multiplier per rule
   always_comb begin
      prod_valid_in = advance ? snap_valid_ff : prod_valid_ff;
      prod_len_in   = prod_len_ff;
      prod_ovl_in   = prod_ovl_ff;
      for (int r = 0; r < NUM_RULES; r++) begin
         prod_in[r]     = prod_ff[r];
         prod_hit_in[r] = prod_hit_ff[r];
      end
      if (advance && snap_valid_ff) begin
         prod_len_in = snap_len_ff;
         prod_ovl_in = snap_ovl_ff;
         for (int r = 0; r < NUM_RULES; r++) begin
            prod_in[r] = ProdBits'(rule_fractions_ff[r*rqff_pkg::FracBits +: rqff_pkg::FracBits])
                       * ProdBits'(snap_len_ff);
            prod_hit_in[r] = snap_hit_ff[r];
         end
      end
   end

   // compare count * 32768 against the product and build the result
   always_comb begin
      logic [ProdBits-1:0] lhs;
      for (int r = 0; r < NUM_RULES; r++) begin
         lhs = ProdBits'({prod_hit_ff[r], {rqff_pkg::FracShift{1'b0}}});
         rule_fail[r] = (rqff_pkg::RuleCountBits'(r) < rule_count_ff) && (lhs < prod_ff[r]);
      end
      len_wide     = 32'(prod_len_ff);
      rsp_valid_in = advance ? prod_valid_ff : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance && prod_valid_ff) begin
         rsp_data_in.rule_pass_mask = '1;
         for (int r = 0; r < NUM_RULES; r++) begin
            rsp_data_in.rule_pass_mask[r] = !rule_fail[r];
         end
         rsp_data_in.keep_read   = (rule_fail == '0) && (prod_len_ff != '0) && !prod_ovl_ff;
         rsp_data_in.read_length = (len_wide > OutLenMax) ? '1
                                 : len_wide[rqff_pkg::OutLenBits-1:0];
         rsp_data_in.overlong    = prod_ovl_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phred_offset_ff    <= rqff_pkg::PhredOffsetRst;
         rule_count_ff      <= rqff_pkg::RuleCountRst;
         rule_thresholds_ff <= '0;
         rule_fractions_ff  <= '0;
         in_valid_ff        <= 1'b0;
         char_count_ff      <= '0;
         overlong_seen_ff   <= 1'b0;
         snap_valid_ff      <= 1'b0;
         prod_valid_ff      <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         for (int r = 0; r < NUM_RULES; r++) begin
            hit_count_ff[r] <= '0;
         end
      end else begin
         phred_offset_ff    <= phred_offset_in;
         rule_count_ff      <= rule_count_in;
         rule_thresholds_ff <= rule_thresholds_in;
         rule_fractions_ff  <= rule_fractions_in;
         in_valid_ff        <= in_valid_in;
         char_count_ff      <= char_count_in;
         overlong_seen_ff   <= overlong_seen_in;
         snap_valid_ff      <= snap_valid_in;
         prod_valid_ff      <= prod_valid_in;
         rsp_valid_ff       <= rsp_valid_in;
         for (int r = 0; r < NUM_RULES; r++) begin
            hit_count_ff[r] <= hit_count_in[r];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      snap_len_ff <= snap_len_in;
      snap_ovl_ff <= snap_ovl_in;
      prod_len_ff <= prod_len_in;
      prod_ovl_ff <= prod_ovl_in;
      rsp_data_ff <= rsp_data_in;
      for (int r = 0; r < NUM_RULES; r++) begin
         snap_hit_ff[r] <= snap_hit_in[r];
         prod_ff[r]     <= prod_in[r];
         prod_hit_ff[r] <= prod_hit_in[r];
      end
   end

   // checks
   `ASSERT_NXT(a_clear_after_close, clock, reset, advance && closing, (char_count_ff == '0) && !overlong_seen_ff, "counters not cleared after closing word")
   `ASSERT_IMP(a_overlong_saturated, clock, reset, overlong_seen_ff, char_count_ff == CntMax, "overlong flag without saturated length")
   `ASSERT_IMP(a_keep_consistent, clock, reset, rsp_valid_ff && rsp_data_ff.keep_read, (rsp_data_ff.read_length != '0) && !rsp_data_ff.overlong && (rsp_data_ff.rule_pass_mask == '1), "kept read is empty, overlong or failed a rule")

endmodule
